### hdl/lbh_pkg.sv
`default_nettype none
package lbh_pkg;

  // Default configuration of the histogram
  localparam int unsigned AlphabetSizeDef = 26;
  localparam int unsigned CountBitsDef    = 32;

  // Code of the first letter in the byte stream
  localparam logic [7:0] LetterBase = 8'd97;

  // Field and result widths fixed by the command interface
  localparam int unsigned LetterW = 5;
  localparam int unsigned OutW    = 32;

  // Command codes
  typedef enum logic [1:0] {
    OP_FEED   = 2'd0,
    OP_READ   = 2'd1,
    OP_REPORT = 2'd2
  } op_e;

  // Compare select of the shared unit
  typedef enum logic {
    CMP_GT = 1'b0,
    CMP_LT = 1'b1
  } cmp_sel_e;

endpackage
`default_nettype wire

### hdl/letter_bigram_histogram.sv
`default_nettype none
// Channel    Direction  Handshake             Payload
// command    in         start & !busy         operation, char_in, first_letter, second_letter
// result     out        done_o, one cycle     pair_count .. empty_flag
//
// A feed byte that does not close a letter pair leaves busy low; one that does keeps busy
// high after the accept (pair RAM read, then pair, row and grand total bumped one after
// another through the shared increment unit). A read gives its beat after the RAM read and
// S_READ_OUT, a report after S_REP_MAX and S_REP_MIN per row past row 0 (two compares
// per row through the shared compare unit) and S_REP_OUT, or in the cycle after the
// command when nothing has been counted yet. Reset: a pass over every pair RAM address
// clears it, with busy high. The receiver cannot stall: each result beat stands one cycle.
module letter_bigram_histogram import lbh_pkg::*; #(
  parameter int unsigned ALPHABET_SIZE = AlphabetSizeDef,
  parameter int unsigned COUNT_BITS    = CountBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         operation_i,
  input  wire logic [7:0]         char_in_i,
  input  wire logic [LetterW-1:0] first_letter_i,
  input  wire logic [LetterW-1:0] second_letter_i,
  output logic                    done_o,
  output logic [OutW-1:0]         pair_count_o,
  output logic [LetterW-1:0]      max_row_o,
  output logic [OutW-1:0]         max_row_total_o,
  output logic [LetterW-1:0]      min_row_o,
  output logic [OutW-1:0]         min_row_total_o,
  output logic [OutW-1:0]         grand_total_o,
  output logic                    empty_flag_o
);

  localparam int unsigned Depth = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned LW    = $clog2(ALPHABET_SIZE);
  localparam int unsigned CW    = COUNT_BITS;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FEED_PAIR,
    S_FEED_ROW,
    S_FEED_TOT,
    S_READ_OUT,
    S_REP_MAX,
    S_REP_MIN,
    S_REP_OUT
  } state_e;

  state_e state_q, state_d;

  logic [IdxW-1:0] clr_q, clr_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [LW-1:0]   row_sel_q, row_sel_d;
  logic [LW-1:0]   prev_q, prev_d;
  logic            prev_ok_q, prev_ok_d;
  logic            rd_ok_q, rd_ok_d;
  logic [CW-1:0]   row_q [ALPHABET_SIZE];
  logic [CW-1:0]   row_d [ALPHABET_SIZE];
  logic [CW-1:0]   total_q, total_d;
  logic [CW-1:0]   maxv_q, maxv_d;
  logic [CW-1:0]   minv_q, minv_d;
  logic [LW-1:0]   maxr_q, maxr_d;
  logic [LW-1:0]   minr_q, minr_d;

  logic               done_q, done_d;
  logic [OutW-1:0]    pair_q, pair_d;
  logic [LetterW-1:0] omaxr_q, omaxr_d;
  logic [OutW-1:0]    omaxv_q, omaxv_d;
  logic [LetterW-1:0] ominr_q, ominr_d;
  logic [OutW-1:0]    ominv_q, ominv_d;
  logic [OutW-1:0]    grand_q, grand_d;
  logic               empty_q, empty_d;

  // RAM and shared unit hookup
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [CW-1:0]   ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  logic [CW-1:0]   ram_rdata;
  logic [CW-1:0]   unit_a;
  logic [CW-1:0]   unit_b;
  cmp_sel_e        unit_sel;
  logic [CW-1:0]   unit_inc;
  logic            unit_hit;

  // Command decode
  logic            accept;
  logic            is_letter;
  logic [LW-1:0]   letter;
  logic            rd_in_range;
  logic [IdxW-1:0] idx_feed;
  logic [IdxW-1:0] idx_read;

  lbh_ram #(
    .WIDTH(CW),
    .DEPTH(Depth)
  ) u_pairs (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  lbh_unit #(
    .W(CW)
  ) u_unit (
    .a_i  (unit_a),
    .b_i  (unit_b),
    .sel_i(unit_sel),
    .inc_o(unit_inc),
    .hit_o(unit_hit)
  );

  // Clip a count to the 32-bit result field
  function automatic logic [OutW-1:0] clip_out(input logic [CW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (|w[63:32]) ? '1 : w[31:0];
  endfunction

  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign is_letter = ({1'b0, char_in_i} >= {1'b0, LetterBase}) &&
                     ({1'b0, char_in_i} < 9'(32'(LetterBase) + ALPHABET_SIZE));
  assign letter   = is_letter ? LW'(char_in_i - LetterBase) : '0;
  assign rd_in_range = (32'(first_letter_i) < ALPHABET_SIZE) &&
                       (32'(second_letter_i) < ALPHABET_SIZE);
  assign idx_feed = IdxW'(32'(prev_q) * ALPHABET_SIZE + 32'(letter));
  assign idx_read = IdxW'(32'(first_letter_i) * ALPHABET_SIZE + 32'(second_letter_i));

  // Sequencer and datapath next state
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    row_sel_d = row_sel_q;
    prev_d    = prev_q;
    prev_ok_d = prev_ok_q;
    rd_ok_d   = rd_ok_q;
    row_d     = row_q;
    total_d   = total_q;
    maxv_d    = maxv_q;
    minv_d    = minv_q;
    maxr_d    = maxr_q;
    minr_d    = minr_q;
    done_d    = 1'b0;
    pair_d    = pair_q;
    omaxr_d   = omaxr_q;
    omaxv_d   = omaxv_q;
    ominr_d   = ominr_q;
    ominv_d   = ominv_q;
    grand_d   = grand_q;
    empty_d   = empty_q;

    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = unit_inc;
    ram_re    = 1'b0;
    ram_raddr = idx_feed;
    unit_a    = ram_rdata;
    unit_b    = maxv_q;
    unit_sel  = CMP_GT;

    case (state_q)
      // Sweep zeros through the pair RAM
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + IdxW'(1);
        if (32'(clr_q) == Depth - 1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_FEED: begin
              prev_d    = letter;
              prev_ok_d = is_letter;
              if (is_letter && prev_ok_q) begin
                ram_re    = 1'b1;
                ram_raddr = idx_feed;
                idx_d     = idx_feed;
                row_sel_d = prev_q;
                state_d   = S_FEED_PAIR;
              end
            end
            OP_READ: begin
              ram_re    = rd_in_range;
              ram_raddr = idx_read;
              rd_ok_d   = rd_in_range;
              state_d   = S_READ_OUT;
            end
            OP_REPORT: begin
              pair_d  = '0;
              grand_d = clip_out(total_q);
              if (total_q == '0) begin
                // Nothing counted: flag empty, extremes zero
                omaxr_d = '0;
                omaxv_d = '0;
                ominr_d = '0;
                ominv_d = '0;
                empty_d = 1'b1;
                done_d  = 1'b1;
              end else begin
                maxv_d    = row_q[0];
                minv_d    = row_q[0];
                maxr_d    = '0;
                minr_d    = '0;
                row_sel_d = LW'(1);
                state_d   = S_REP_MAX;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Bump the pair count and write it back
      S_FEED_PAIR: begin
        unit_a  = ram_rdata;
        ram_we  = 1'b1;
        state_d = S_FEED_ROW;
      end

      // Bump the row total
      S_FEED_ROW: begin
        unit_a             = row_q[row_sel_q];
        row_d[row_sel_q]   = unit_inc;
        state_d            = S_FEED_TOT;
      end

      // Bump the grand total
      S_FEED_TOT: begin
        unit_a  = total_q;
        total_d = unit_inc;
        state_d = S_IDLE;
      end

      S_READ_OUT: begin
        pair_d  = rd_ok_q ? clip_out(ram_rdata) : '0;
        omaxr_d = '0;
        omaxv_d = '0;
        ominr_d = '0;
        ominv_d = '0;
        grand_d = '0;
        empty_d = 1'b0;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      // Strictly larger row takes the maximum
      S_REP_MAX: begin
        unit_a   = row_q[row_sel_q];
        unit_b   = maxv_q;
        unit_sel = CMP_GT;
        if (unit_hit) begin
          maxv_d = row_q[row_sel_q];
          maxr_d = row_sel_q;
        end
        state_d = S_REP_MIN;
      end

      // Strictly smaller row takes the minimum, then advance
      S_REP_MIN: begin
        unit_a   = row_q[row_sel_q];
        unit_b   = minv_q;
        unit_sel = CMP_LT;
        if (unit_hit) begin
          minv_d = row_q[row_sel_q];
          minr_d = row_sel_q;
        end
        if (32'(row_sel_q) == ALPHABET_SIZE - 1) begin
          state_d = S_REP_OUT;
        end else begin
          row_sel_d = row_sel_q + LW'(1);
          state_d   = S_REP_MAX;
        end
      end

      S_REP_OUT: begin
        omaxr_d = LetterW'(maxr_q);
        omaxv_d = clip_out(maxv_q);
        ominr_d = LetterW'(minr_q);
        ominv_d = clip_out(minv_q);
        empty_d = 1'b0;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      prev_q    <= '0;
      prev_ok_q <= 1'b0;
      total_q   <= '0;
      done_q    <= 1'b0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        row_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      prev_q    <= prev_d;
      prev_ok_q <= prev_ok_d;
      total_q   <= total_d;
      done_q    <= done_d;
      row_q     <= row_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    row_sel_q <= row_sel_d;
    rd_ok_q   <= rd_ok_d;
    maxv_q    <= maxv_d;
    minv_q    <= minv_d;
    maxr_q    <= maxr_d;
    minr_q    <= minr_d;
    pair_q    <= pair_d;
    omaxr_q   <= omaxr_d;
    omaxv_q   <= omaxv_d;
    ominr_q   <= ominr_d;
    ominv_q   <= ominv_d;
    grand_q   <= grand_d;
    empty_q   <= empty_d;
  end

  assign done_o          = done_q;
  assign pair_count_o    = pair_q;
  assign max_row_o       = omaxr_q;
  assign max_row_total_o = omaxv_q;
  assign min_row_o       = ominr_q;
  assign min_row_total_o = ominv_q;
  assign grand_total_o   = grand_q;
  assign empty_flag_o    = empty_q;

endmodule
`default_nettype wire

### hdl/lbh_ram.sv
`default_nettype none
module lbh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 676
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hdl/lbh_unit.sv
`default_nettype none
module lbh_unit import lbh_pkg::*; #(
  parameter int unsigned W = CountBitsDef
) (
  input  wire logic     [W-1:0] a_i,
  input  wire logic     [W-1:0] b_i,
  input  wire cmp_sel_e         sel_i,
  output logic          [W-1:0] inc_o,
  output logic                  hit_o
);

  logic gt;
  logic lt;

  // Saturating increment: hold at full scale
  assign inc_o = (&a_i) ? a_i : a_i + W'(1);

  // One magnitude compare, both senses
  assign gt = (a_i > b_i);
  assign lt = (a_i < b_i);

  always_comb begin
    case (sel_i)
      CMP_GT:  hit_o = gt;
      CMP_LT:  hit_o = lt;
      default: hit_o = 1'b0;
    endcase
  end

endmodule
`default_nettype wire
